>>> hdl/wsfb_pkg.sv
// Shared types and constants of the weather sensor frame builder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package wsfb_pkg;

  // Configuration register indexes.
  localparam logic [3:0] CFG_CHANNEL = 4'd0;
  localparam logic [3:0] CFG_ROLLING = 4'd1;

  // Saturation limits and reciprocals for the digit split.
  localparam logic [9:0] MAG_MAX  = 10'd999;
  localparam logic [6:0] HUM_MAX  = 7'd99;
  localparam logic [5:0] RECIP100 = 6'd41;   // x * 41 >> 12 == x / 100 for x < 1000
  localparam logic [7:0] RECIP10  = 8'd205;  // x * 205 >> 11 == x / 10 for x < 100

  // Fixed frame content.
  localparam logic [7:0] PREAMBLE  = 8'hFF;
  localparam logic [7:0] SYNC_ID   = 8'hAF;
  localparam logic [7:0] SENSOR_ID = 8'h82;
  localparam logic [3:0] ID_LOW    = 4'h4;
  localparam logic [3:0] BATT_FLAG = 4'h8;
  localparam logic [3:0] NEG_FLAG  = 4'h8;

  // Nibbles that never change: low nibble of the sync byte, both of the sensor
  // id byte, the id nibble of byte five and the battery flag.
  localparam logic [7:0] CHK_BASE = 8'h0F + 8'h08 + 8'h02 + 8'h04 + 8'h08;

  localparam logic [3:0] LAST_IDX = 4'd11;

  typedef struct packed {
    logic       neg;
    logic [3:0] t_hund;
    logic [3:0] t_tens;
    logic [3:0] t_ones;
    logic [3:0] h_tens;
    logic [3:0] h_ones;
  } wsfb_digits_t;

  typedef struct packed {
    wsfb_digits_t dig;
    logic [7:0]   chk;
  } wsfb_frame_t;

endpackage
`default_nettype wire

>>> hdl/wsfb_bcd.sv
// Three-stage front end: sign and saturation, then BCD digit split.
// Depends on wsfb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wsfb_bcd import wsfb_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic signed [10:0]  temperature_tenths_i,
  input  wire logic [6:0]          humidity_i,
  output      logic                dig_valid_o,
  input  wire logic                dig_stall_i,
  output      wsfb_digits_t        dig_o
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  // Stage 1 payload.
  logic       neg1_q;
  logic [9:0] mag1_q, mag1_d;
  logic [6:0] hum1_q, hum1_d;
  logic [10:0] abs_v;

  // Stage 2 payload.
  logic       neg2_q;
  logic [3:0] hund2_q, hund2_d;
  logic [6:0] rem2_q, rem2_d;
  logic [3:0] htens2_q, htens2_d;
  logic [3:0] hones2_q, hones2_d;
  logic [15:0] prod100;
  logic [14:0] prodh;

  // Stage 3 payload.
  wsfb_digits_t dig3_q, dig3_d;
  logic [14:0] prodt;

  assign rdy3 = !v3_q || !dig_stall_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  always_comb begin
    abs_v = temperature_tenths_i[10] ? (~temperature_tenths_i + 11'd1)
                                     : temperature_tenths_i;
    mag1_d = (abs_v > {1'b0, MAG_MAX}) ? MAG_MAX : abs_v[9:0];
    hum1_d = (humidity_i > HUM_MAX) ? HUM_MAX : humidity_i;
  end

  always_comb begin
    prod100  = {6'd0, mag1_q} * {10'd0, RECIP100};
    hund2_d  = prod100[15:12];
    rem2_d   = 7'(mag1_q - 10'(hund2_d) * 10'd100);
    prodh    = {8'd0, hum1_q} * {7'd0, RECIP10};
    htens2_d = prodh[14:11];
    hones2_d = 4'(hum1_q - 7'(htens2_d) * 7'd10);
  end

  always_comb begin
    prodt         = {8'd0, rem2_q} * {7'd0, RECIP10};
    dig3_d.neg    = neg2_q;
    dig3_d.t_hund = hund2_q;
    dig3_d.t_tens = prodt[14:11];
    dig3_d.t_ones = 4'(rem2_q - 7'(prodt[14:11]) * 7'd10);
    dig3_d.h_tens = htens2_q;
    dig3_d.h_ones = hones2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      neg1_q <= temperature_tenths_i[10];
      mag1_q <= mag1_d;
      hum1_q <= hum1_d;
    end
    if (rdy2 && v1_q) begin
      neg2_q   <= neg1_q;
      hund2_q  <= hund2_d;
      rem2_q   <= rem2_d;
      htens2_q <= htens2_d;
      hones2_q <= hones2_d;
    end
    if (rdy3 && v2_q) begin
      dig3_q <= dig3_d;
    end
  end

  assign dig_valid_o = v3_q;
  assign dig_o       = dig3_q;

endmodule
`default_nettype wire

>>> hdl/wsfb_chk.sv
// Checksum stage: nibble sum of the frame from the low sync nibble on, fixed nibbles included, nibble-swapped.
// Depends on wsfb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wsfb_chk import wsfb_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [3:0]   channel_i,
  input  wire logic [7:0]   rolling_code_i,
  input  wire logic         dig_valid_i,
  output      logic         dig_stall_o,
  input  wire wsfb_digits_t dig_i,
  output      logic         frm_valid_o,
  input  wire logic         frm_stall_i,
  output      wsfb_frame_t  frm_o
);

  logic        v_q;
  logic        rdy;
  logic [7:0]  sum;
  wsfb_frame_t frm_q, frm_d;

  assign rdy = !v_q || !frm_stall_i;
  assign dig_stall_o = !rdy;

  always_comb begin
    sum = CHK_BASE + {4'd0, channel_i} + {4'd0, rolling_code_i[7:4]}
        + {4'd0, rolling_code_i[3:0]} + {4'd0, dig_i.t_ones}
        + {4'd0, dig_i.t_tens} + {4'd0, dig_i.t_hund}
        + (dig_i.neg ? {4'd0, NEG_FLAG} : 8'd0)
        + {4'd0, dig_i.h_ones} + {4'd0, dig_i.h_tens};
    frm_d.dig = dig_i;
    frm_d.chk = {sum[3:0], sum[7:4]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= dig_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && dig_valid_i) begin
      frm_q <= frm_d;
    end
  end

  assign frm_valid_o = v_q;
  assign frm_o       = frm_q;

endmodule
`default_nettype wire

>>> hdl/wsfb_ser.sv
// Output serializer: holds one finished frame and sends its 12 bytes in order.
// Depends on wsfb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wsfb_ser import wsfb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [3:0]  channel_i,
  input  wire logic [7:0]  rolling_code_i,
  input  wire logic        frm_valid_i,
  output      logic        frm_stall_o,
  input  wire wsfb_frame_t frm_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [7:0]  frame_byte_o,
  output      logic [3:0]  byte_index_o,
  output      logic        last_o
);

  logic        valid_q, valid_d;
  logic [3:0]  cnt_q, cnt_d;
  wsfb_frame_t frm_q;
  logic        take;
  logic        load;

  // A new frame may load while the last byte of the current one is taken.
  assign take = valid_q && !out_stall_i;
  assign load = !valid_q || (take && (cnt_q == LAST_IDX));
  assign frm_stall_o = !load;

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    if (load) begin
      valid_d = frm_valid_i;
      cnt_d   = 4'd0;
    end else if (take) begin
      cnt_d = cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 4'd0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && frm_valid_i) begin
      frm_q <= frm_i;
    end
  end

  always_comb begin
    unique case (cnt_q)
      4'd0, 4'd1, 4'd2: frame_byte_o = PREAMBLE;
      4'd3:  frame_byte_o = SYNC_ID;
      4'd4:  frame_byte_o = SENSOR_ID;
      4'd5:  frame_byte_o = {ID_LOW, channel_i};
      4'd6:  frame_byte_o = rolling_code_i;
      4'd7:  frame_byte_o = {BATT_FLAG, frm_q.dig.t_ones};
      4'd8:  frame_byte_o = {frm_q.dig.t_tens, frm_q.dig.t_hund};
      4'd9:  frame_byte_o = {(frm_q.dig.neg ? NEG_FLAG : 4'h0), frm_q.dig.h_ones};
      4'd10: frame_byte_o = {frm_q.dig.h_tens, 4'h0};
      4'd11: frame_byte_o = frm_q.chk;
      default: frame_byte_o = 8'h00;
    endcase
  end

  assign out_valid_o  = valid_q;
  assign byte_index_o = cnt_q;
  assign last_o       = (cnt_q == LAST_IDX);

endmodule
`default_nettype wire

>>> hdl/weather_sensor_frame_builder.sv
// Weather sensor frame builder.
// Each reading beat (temperature in signed tenths, humidity in percent) on
// the input channel becomes 12 frame beats on the output channel, in
// transmission order, each with its byte index; last marks the checksum byte.
// Both channels use valid/stall; a beat moves on a clock edge with valid high
// and stall low. The channel and rolling code registers are written through
// the cfg port (index 0 and 1); the user must write them only while no
// frame is in flight, which the block does not enforce. A frame's first
// byte follows its reading through the registers in turn: the accepting
// edge registers sign and saturation, then come the hundreds split, tens
// split, checksum and the output register. Throughput: one byte per cycle
// while out_stall_i is low, set by the single-byte output port; the next
// reading is taken while the current frame is still being sent, and up to
// four readings wait in the pipeline stages.
// Reset clears all valid bits and sets channel and rolling code to 1.
// A stalled output holds its byte and the pipeline stages fill behind it;
// once full, in_stall_o is raised. Nothing is dropped or repeated.
// Depends on wsfb_pkg, wsfb_bcd, wsfb_chk and wsfb_ser.
`timescale 1ns / 1ps
`default_nettype none
module weather_sensor_frame_builder import wsfb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [3:0]         cfg_index_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic signed [10:0] temperature_tenths_i,
  input  wire logic [6:0]         humidity_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [7:0]         frame_byte_o,
  output      logic [3:0]         byte_index_o,
  output      logic               last_o
);

  logic [3:0]   channel_q;
  logic [7:0]   rolling_code_q;
  logic         dig_valid, dig_stall;
  wsfb_digits_t dig;
  logic         frm_valid, frm_stall;
  wsfb_frame_t  frm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q      <= 4'd1;
      rolling_code_q <= 8'd1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_CHANNEL) channel_q <= cfg_wdata_i[3:0];
      if (cfg_index_i == CFG_ROLLING) rolling_code_q <= cfg_wdata_i;
    end
  end

  wsfb_bcd u_bcd (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .temperature_tenths_i (temperature_tenths_i),
    .humidity_i           (humidity_i),
    .dig_valid_o          (dig_valid),
    .dig_stall_i          (dig_stall),
    .dig_o                (dig)
  );

  wsfb_chk u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .channel_i      (channel_q),
    .rolling_code_i (rolling_code_q),
    .dig_valid_i    (dig_valid),
    .dig_stall_o    (dig_stall),
    .dig_i          (dig),
    .frm_valid_o    (frm_valid),
    .frm_stall_i    (frm_stall),
    .frm_o          (frm)
  );

  wsfb_ser u_ser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .channel_i      (channel_q),
    .rolling_code_i (rolling_code_q),
    .frm_valid_i    (frm_valid),
    .frm_stall_o    (frm_stall),
    .frm_i          (frm),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_byte_o   (frame_byte_o),
    .byte_index_o   (byte_index_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire
